### rtl/mdm_pkg.sv
// Shared types and constants for the motor drive mode controller.
package mdm_pkg;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_ACCEL   = 3'd1,
    MODE_RUN     = 3'd2,
    MODE_DECEL   = 3'd3,
    MODE_CHDIR   = 3'd4,
    MODE_EMERG   = 3'd5,
    MODE_BRAKE   = 3'd6
  } mode_t;

  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_REV   = 2'd1;
  localparam logic [1:0] DIR_BRAKE = 2'd2;
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  localparam logic [15:0] SLOW_SPEED_RESET = 16'd6;

  typedef struct packed {
    logic        load_target;
    logic [1:0]  new_target_dir;
    logic [9:0]  new_target_duty;
    logic [15:0] measured_speed;
    logic        emergency_active;
    logic        brake_request;
  } tick_word_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       relay_level;
    logic       relay_changed;
    logic [9:0] duty_out;
    logic [1:0] drive_dir;
  } drive_word_t;

endpackage

### rtl/mdm_if.sv
// Valid/ready channel interfaces for the tick and drive words.
interface mdm_tick_if;
  import mdm_pkg::*;
  logic       valid;
  logic       ready;
  tick_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mdm_drive_if;
  import mdm_pkg::*;
  logic        valid;
  logic        ready;
  drive_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/motor_drive_mode_fsm_core.sv
// Motor drive mode controller: tick word in, mode, relay, duty and direction word out.
//
//   channel   kind       direction  word
//   tick      valid/rdy  sink       tick_word_t (target, speed, emergency, brake)
//   drive     valid/rdy  source     drive_word_t (mode, relay, duty, direction)
//   cfg       write      sink       slow speed threshold, 16 bits
//
// A tick word is registered in the input register on acceptance and its drive word
// is then registered in the output register; one word can be accepted every cycle
// while the drive side does not stall. The mode and drive state update with it.
// A stalled drive word holds the input register; the tick side stays ready while
// either register is free. Synchronous reset restores the power-up mode and
// a threshold of 6.
module motor_drive_mode_fsm_core #(
  parameter int unsigned FULL_DUTY = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  mdm_tick_if.sink           tick,
  mdm_drive_if.source        drive
);
  import mdm_pkg::*;

  localparam logic [9:0] DUTY_LIMIT = (FULL_DUTY > 1023) ? 10'd1023 : 10'(FULL_DUTY);

  logic [15:0] slow_speed_threshold;
  mode_t       mode_state, mode_state_next;
  logic [1:0]  target_dir, target_dir_next;
  logic [9:0]  goal_duty, goal_duty_next;
  logic [1:0]  current_dir, current_dir_next;
  logic [9:0]  motor_duty, motor_duty_next;
  logic [9:0]  applied_duty, applied_duty_next;
  logic [1:0]  applied_dir, applied_dir_next;
  logic        relay_state, relay_state_next;

  tick_word_t  s1_data;
  logic        s1_valid;
  logic        s1_advance;
  logic        s1_fire;
  drive_word_t out_data;
  logic        out_valid;

  logic [1:0]  tdir;
  logic [9:0]  tduty;

  assign s1_advance = !out_valid || drive.ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign tick.ready = !s1_valid || s1_advance;
  assign drive.valid = out_valid;
  assign drive.data  = out_data;

  always_comb begin
    tdir  = target_dir;
    tduty = goal_duty;
    if (s1_data.load_target) begin
      tdir  = (s1_data.new_target_dir == DIR_UNUSED) ? DIR_BRAKE : s1_data.new_target_dir;
      tduty = (s1_data.new_target_duty > DUTY_LIMIT) ? DUTY_LIMIT : s1_data.new_target_duty;
    end

    mode_state_next = mode_state;
    if (s1_data.emergency_active) begin
      mode_state_next = MODE_EMERG;
    end else if (s1_data.brake_request) begin
      mode_state_next = MODE_BRAKE;
    end else begin
      case (mode_state)
        MODE_STOPPED: begin
          if (tdir != current_dir) mode_state_next = MODE_CHDIR;
          else if (tduty != 10'd0) mode_state_next = MODE_ACCEL;
        end
        MODE_CHDIR: begin
          mode_state_next = (tduty == 10'd0) ? MODE_STOPPED : MODE_ACCEL;
        end
        MODE_ACCEL, MODE_RUN: begin
          if (tduty == 10'd0) mode_state_next = MODE_DECEL;
          else if (current_dir != tdir) mode_state_next = MODE_DECEL;
          else if (tduty < motor_duty) mode_state_next = MODE_DECEL;
          else if (tduty > motor_duty) mode_state_next = MODE_ACCEL;
          else mode_state_next = MODE_RUN;
        end
        MODE_DECEL: begin
          if (s1_data.measured_speed < slow_speed_threshold) mode_state_next = MODE_CHDIR;
          else if (tduty > motor_duty) mode_state_next = MODE_ACCEL;
        end
        MODE_EMERG: begin
          if (tduty == 10'd0) mode_state_next = MODE_STOPPED;
          else if (tdir != current_dir) mode_state_next = MODE_CHDIR;
          else if (tduty > motor_duty) mode_state_next = MODE_ACCEL;
          else mode_state_next = MODE_DECEL;
        end
        MODE_BRAKE: mode_state_next = MODE_CHDIR;
        default: mode_state_next = mode_state;
      endcase
    end

    target_dir_next   = tdir;
    goal_duty_next    = tduty;
    current_dir_next  = current_dir;
    motor_duty_next   = motor_duty;
    applied_duty_next = applied_duty;
    applied_dir_next  = applied_dir;
    relay_state_next  = relay_state;

    case (mode_state_next)
      MODE_STOPPED: relay_state_next = 1'b0;
      MODE_ACCEL, MODE_RUN, MODE_DECEL: begin
        relay_state_next = 1'b1;
        if (tdir != current_dir) begin
          applied_duty_next = 10'd0;
        end else begin
          motor_duty_next   = tduty;
          applied_duty_next = tduty;
        end
      end
      MODE_CHDIR: begin
        relay_state_next = 1'b1;
        applied_dir_next = tdir;
        current_dir_next = tdir;
      end
      MODE_BRAKE: begin
        // A differing direction loads full duty; a matching one takes the target duty.
        relay_state_next = 1'b1;
        if (tdir != current_dir) begin
          motor_duty_next   = DUTY_LIMIT;
          applied_duty_next = 10'd0;
        end else begin
          motor_duty_next   = tduty;
          applied_duty_next = tduty;
        end
        target_dir_next  = DIR_BRAKE;
        applied_dir_next = DIR_BRAKE;
      end
      default: relay_state_next = relay_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_speed_threshold <= SLOW_SPEED_RESET;
    end else if (cfg_wr_en) begin
      slow_speed_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state   <= MODE_STOPPED;
      target_dir   <= DIR_FWD;
      goal_duty    <= 10'd0;
      current_dir  <= DIR_FWD;
      motor_duty   <= 10'd0;
      applied_duty <= 10'd0;
      applied_dir  <= DIR_FWD;
      relay_state  <= 1'b0;
    end else if (s1_fire) begin
      mode_state   <= mode_state_next;
      target_dir   <= target_dir_next;
      goal_duty    <= goal_duty_next;
      current_dir  <= current_dir_next;
      motor_duty   <= motor_duty_next;
      applied_duty <= applied_duty_next;
      applied_dir  <= applied_dir_next;
      relay_state  <= relay_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_data <= tick.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data.mode          <= mode_state_next;
      out_data.relay_level   <= relay_state_next;
      out_data.relay_changed <= relay_state_next != relay_state;
      out_data.duty_out      <= applied_duty_next;
      out_data.drive_dir     <= applied_dir_next;
    end
  end

`ifndef SYNTHESIS
  // The tick side may only stall while both registers are occupied.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> (s1_valid && out_valid && !drive.ready))
    else $error("tick channel stalled with a free register");

  a_stopped_relay_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mode == MODE_STOPPED) |-> !out_data.relay_level)
    else $error("relay on in stopped mode");

  a_brake_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.mode == MODE_BRAKE) |-> (out_data.drive_dir == DIR_BRAKE))
    else $error("brake mode without brake direction");

  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.duty_out <= DUTY_LIMIT && motor_duty <= DUTY_LIMIT))
    else $error("duty above full duty limit");

  // A word that goes out reflects the relay state the registers now hold.
  a_relay_tracks: assert property (@(posedge clk) disable iff (rst)
    (s1_fire) |=> (out_data.relay_level == relay_state))
    else $error("reported relay level differs from relay state");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the motor drive mode controller core.
`timescale 1ns / 1ps

module testbench;
  import mdm_pkg::*;

  localparam int unsigned FULL_DUTY = 1000;
  localparam logic [9:0] DUTY_CAP = (FULL_DUTY > 1023) ? 10'd1023 : 10'(FULL_DUTY);

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  mdm_tick_if tick_ch();
  mdm_drive_if drive_ch();

  motor_drive_mode_fsm_core #(
    .FULL_DUTY(FULL_DUTY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .tick(tick_ch),
    .drive(drive_ch)
  );

  // Predicted controller state.
  mode_t mode_st = MODE_STOPPED;
  logic [1:0] tgt_dir = DIR_FWD;
  logic [9:0] tgt_duty = '0;
  logic [1:0] cur_dir = DIR_FWD;
  logic [9:0] cur_duty = '0;
  logic [9:0] app_duty = '0;
  logic [1:0] app_dir = DIR_FWD;
  logic relay_st = 1'b0;
  logic [15:0] slow_thr = SLOW_SPEED_RESET;

  tick_word_t pending_ticks[$];
  drive_word_t expected_drive_q[$];
  drive_word_t want_drive;
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned mismatches = 0;
  int unsigned tick_gap = 0;
  int unsigned drive_stall = 0;
  bit calm_gaps = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void apply_pwm();
    if (tgt_dir != cur_dir) begin
      app_duty = '0;
    end else begin
      cur_duty = tgt_duty;
      app_duty = cur_duty;
    end
  endfunction

  function automatic drive_word_t predict_drive(tick_word_t t);
    drive_word_t r;
    logic old_relay;
    mode_t nm;
    old_relay = relay_st;
    if (t.load_target) begin
      tgt_dir = (t.new_target_dir == DIR_UNUSED) ? DIR_BRAKE : t.new_target_dir;
      tgt_duty = (t.new_target_duty > DUTY_CAP) ? DUTY_CAP : t.new_target_duty;
    end
    nm = mode_st;
    if (t.emergency_active) begin
      nm = MODE_EMERG;
    end else if (t.brake_request) begin
      nm = MODE_BRAKE;
    end else begin
      case (mode_st)
        MODE_STOPPED: begin
          if (tgt_dir != cur_dir) nm = MODE_CHDIR;
          else if (tgt_duty != 0) nm = MODE_ACCEL;
        end
        MODE_CHDIR: nm = (tgt_duty == 0) ? MODE_STOPPED : MODE_ACCEL;
        MODE_ACCEL, MODE_RUN: begin
          if (tgt_duty == 0 || cur_dir != tgt_dir || tgt_duty < cur_duty) nm = MODE_DECEL;
          else if (tgt_duty > cur_duty) nm = MODE_ACCEL;
          else nm = MODE_RUN;
        end
        MODE_DECEL: begin
          if (t.measured_speed < slow_thr) nm = MODE_CHDIR;
          else if (tgt_duty > cur_duty) nm = MODE_ACCEL;
        end
        MODE_EMERG: begin
          if (tgt_duty == 0) nm = MODE_STOPPED;
          else if (tgt_dir != cur_dir) nm = MODE_CHDIR;
          else if (tgt_duty > cur_duty) nm = MODE_ACCEL;
          else nm = MODE_DECEL;
        end
        MODE_BRAKE: nm = MODE_CHDIR;
        default: ;
      endcase
    end
    mode_st = nm;
    case (nm)
      MODE_STOPPED: relay_st = 1'b0;
      MODE_ACCEL, MODE_RUN, MODE_DECEL: begin
        relay_st = 1'b1;
        apply_pwm();
      end
      MODE_CHDIR: begin
        relay_st = 1'b1;
        app_dir = tgt_dir;
        cur_dir = tgt_dir;
      end
      MODE_BRAKE: begin
        relay_st = 1'b1;
        cur_duty = DUTY_CAP;
        apply_pwm();
        tgt_dir = DIR_BRAKE;
        app_dir = DIR_BRAKE;
      end
      default: ;
    endcase
    r.mode = nm;
    r.relay_level = relay_st;
    r.relay_changed = (relay_st != old_relay);
    r.duty_out = app_duty;
    r.drive_dir = app_dir;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none at all while calm_gaps is set.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tick_word_t make_tick(logic load, logic [1:0] dir, logic [9:0] duty,
                                           logic [15:0] speed, logic emerg, logic brake);
    tick_word_t w;
    w.load_target = load;
    w.new_target_dir = dir;
    w.new_target_duty = duty;
    w.measured_speed = speed;
    w.emergency_active = emerg;
    w.brake_request = brake;
    return w;
  endfunction

  // Plausible control ticks with occasional fully random words mixed in.
  function automatic tick_word_t random_tick();
    tick_word_t w;
    int unsigned r;
    int unsigned thr;
    thr = 32'(slow_thr);
    w = '0;
    if ($urandom_range(0, 9) == 0) begin
      w = tick_word_t'(31'($urandom()));
      return w;
    end
    w.load_target = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 40) w.new_target_dir = DIR_FWD;
    else if (r < 80) w.new_target_dir = DIR_REV;
    else if (r < 92) w.new_target_dir = DIR_BRAKE;
    else w.new_target_dir = DIR_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 10) w.new_target_duty = '0;
    else if (r < 20) w.new_target_duty = 10'($urandom_range(1001, 1023));
    else if (r < 25) w.new_target_duty = DUTY_CAP;
    else w.new_target_duty = 10'($urandom_range(1, 999));
    r = $urandom_range(0, 99);
    if (r < 40 && thr != 0) w.measured_speed = 16'($urandom_range(0, thr - 1));
    else if (r < 45) w.measured_speed = '0;
    else if (r < 50) w.measured_speed = 16'hFFFF;
    else if (r < 75) w.measured_speed = 16'($urandom_range(thr, 65535));
    else w.measured_speed = 16'($urandom());
    w.emergency_active = ($urandom_range(0, 39) == 0);
    w.brake_request = ($urandom_range(0, 29) == 0);
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_tick(tick_word_t w);
    pending_ticks.push_back(w);
    queued_total++;
  endtask

  // Holds the sender until every queued word has been answered.
  task automatic wait_idle();
    while (accepted_total != queued_total || checked_total != accepted_total)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slow_thr = v;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) queue_tick(random_tick());
    wait_idle();
  endtask

  // Tick side driver.
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tick_gap = 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        expected_drive_q.push_back(predict_drive(tick_ch.data));
        accepted_total++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tick_gap > 0) begin
          tick_gap--;
          tick_ch.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          tick_ch.data <= pending_ticks.pop_front();
          tick_ch.valid <= 1'b1;
          tick_gap = next_gap();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Drive side monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      drive_ch.ready <= 1'b0;
      drive_stall = 0;
    end else begin
      if (drive_ch.valid && drive_ch.ready) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: drive word %h arrived with none expected", $time, drive_ch.data);
          mismatches++;
        end else begin
          want_drive = expected_drive_q.pop_front();
          check_field("mode", 32'(want_drive.mode), 32'(drive_ch.data.mode));
          check_field("relay_level", 32'(want_drive.relay_level),
                      32'(drive_ch.data.relay_level));
          check_field("relay_changed", 32'(want_drive.relay_changed),
                      32'(drive_ch.data.relay_changed));
          check_field("duty_out", 32'(want_drive.duty_out), 32'(drive_ch.data.duty_out));
          check_field("drive_dir", 32'(want_drive.drive_dir), 32'(drive_ch.data.drive_dir));
          checked_total++;
        end
      end
      if (drive_stall > 0) begin
        drive_stall--;
        drive_ch.ready <= 1'b0;
      end else begin
        drive_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) drive_stall = next_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.data = '0;
    drive_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk through every mode with the reset threshold of 6.
    queue_tick(make_tick(0, DIR_FWD, 0, 0, 0, 0));
    queue_tick(make_tick(1, DIR_FWD, 500, 100, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 100, 0, 0));
    queue_tick(make_tick(1, DIR_FWD, 10'd1023, 100, 0, 0));
    queue_tick(make_tick(1, DIR_FWD, 200, 1000, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 16'hFFFF, 0, 0));
    queue_tick(make_tick(1, DIR_REV, 300, 100, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 100, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 5, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 5, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 5, 1, 0));
    queue_tick(make_tick(1, DIR_UNUSED, 0, 5, 0, 0));
    queue_tick(make_tick(1, DIR_REV, 700, 5, 0, 1));
    queue_tick(make_tick(0, DIR_FWD, 0, 6, 0, 0));
    queue_tick(make_tick(1, DIR_FWD, 0, 6, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 6, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 6, 0, 0));
    queue_tick(make_tick(1, DIR_FWD, 800, 6, 1, 1));
    queue_tick(make_tick(0, DIR_FWD, 0, 6, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 6, 1, 0));
    queue_tick(make_tick(1, DIR_FWD, 100, 6, 0, 0));
    queue_tick(make_tick(0, DIR_FWD, 0, 0, 0, 0));
    queue_tick(make_tick(1, DIR_BRAKE, 1000, 16'hFFFF, 1, 0));
    queue_tick(make_tick(1, DIR_REV, 10'h3FF, 16'hFFFF, 0, 0));
    wait_idle();

    // A zero threshold never lets deceleration end on speed.
    write_threshold(16'd0);
    run_random(250);

    calm_gaps = 1'b1;
    write_threshold(16'hFFFF);
    run_random(250);
    calm_gaps = 1'b0;

    write_threshold(16'($urandom_range(7, 2000)));
    run_random(250);

    write_threshold(SLOW_SPEED_RESET);
    run_random(280);

    if (mismatches == 0 && expected_drive_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### motor_drive_mode_fsm_core.f
rtl/mdm_pkg.sv
rtl/mdm_if.sv
rtl/motor_drive_mode_fsm_core.sv
verif/testbench.sv
